// ===== hdl/ctpc_pkg.sv =====
// ctpc_pkg: beat types and fixed field widths for the count tree pair counter
// used by count_tree_pair_counter_unit; depends on nothing else

package ctpc_pkg;

    // fixed field widths of the input and result beats
    localparam int THR_W = 10;
    localparam int KEY_W = 10;
    localparam int GC_W  = 11;
    localparam int TOT_W = 19;

    // epoch tag kept next to every tree node count
    localparam int                 EPOCH_W    = 6;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};

    typedef struct packed {
        logic             batch_start;
        logic [THR_W-1:0] threshold;
        logic [KEY_W-1:0] new_key;
    } t_in_beat;

    typedef struct packed {
        logic [GC_W-1:0]  greater_count;
        logic [TOT_W-1:0] pair_total;
        logic             overflow;
    } t_out_beat;

endpackage

// ===== hdl/ctpc_ram.sv =====
// ctpc_ram: generic memory, one write port and two registered read ports
// standalone, no package needed

module ctpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/count_tree_pair_counter_unit.sv =====
// count_tree_pair_counter_unit: counting segment tree with a running pair total
// depends on ctpc_pkg (beat types, widths) and ctpc_ram (node count store)
//
//  channel   valid        stall        beat           direction
//  input     i_in_valid   o_in_stall   i_in_beat      into the block
//  result    o_out_valid  i_out_stall  o_out_beat     out of the block
//
// one beat is taken only in idle; for a normal item the time from accept to the next
//   accept is set by the insert walk, one tree level per cycle through the node
//   store's second read port
// an overflowed item (batch already full) skips the walk and goes straight to done
// reset starts a clearing pass over all 2 << $clog2(LEAVES) node entries (2048 at
//   the default); the same pass runs on every 64th batch start, when the epoch
//   tag wraps, and the input stays stalled meanwhile
// the result register lets the next beat in while a result waits on i_out_stall

module count_tree_pair_counter_unit
    import ctpc_pkg::*;
#(
    parameter int LEAVES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    // key value width, node index width, count width
    localparam int PW    = $clog2(LEAVES);
    localparam int VW    = (PW > THR_W) ? PW : THR_W;
    localparam int AW    = PW + 1;
    localparam int NODES = 2 ** AW;
    localparam int CW    = $clog2(LEAVES + 1);
    localparam int MW    = CW + EPOCH_W;

    localparam logic [VW-1:0] LAST_KEY   = VW'(LEAVES - 1);
    localparam logic [CW-1:0] FULL_BATCH = CW'(LEAVES);
    localparam logic [AW-1:0] NODE_LAST  = {AW{1'b1}};

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // control state
    logic [1:0]         r_state,     n_state;
    logic [AW-1:0]      r_clr_addr,  n_clr_addr;
    logic [EPOCH_W-1:0] r_epoch,     n_epoch;
    logic [CW-1:0]      r_items,     n_items;
    logic [TOT_W-1:0]   r_total,     n_total;
    logic               r_pend,      n_pend;
    logic               r_out_valid, n_out_valid;
    logic               r_q_act,     n_q_act;
    logic               r_q_rd,      n_q_rd;
    logic               r_u_act,     n_u_act;
    logic               r_u_wr,      n_u_wr;

    // payload
    logic               r_ovf,       n_ovf;
    logic [VW-1:0]      r_thr,       n_thr;
    logic [VW-1:0]      r_key,       n_key;
    logic [AW-1:0]      r_q_node,    n_q_node;
    logic [VW-1:0]      r_q_lo,      n_q_lo;
    logic [VW-1:0]      r_q_hi,      n_q_hi;
    logic [AW-1:0]      r_u_node,    n_u_node;
    logic [VW-1:0]      r_u_lo,      n_u_lo;
    logic [VW-1:0]      r_u_hi,      n_u_hi;
    logic [AW-1:0]      r_u_waddr,   n_u_waddr;
    logic [CW-1:0]      r_acc,       n_acc;
    t_out_beat          r_out_beat,  n_out_beat;

    // walk step logic
    logic [VW-1:0]      q_mid;
    logic               q_left;
    logic [AW-1:0]      q_lc;
    logic [AW-1:0]      q_rc;
    logic [VW-1:0]      u_mid;
    logic               u_left;
    logic [AW-1:0]      u_lc;
    logic [AW-1:0]      u_rc;
    logic [TOT_W-1:0]   sum_total;

    // node store ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [MW-1:0]      ram_wdata;
    logic [MW-1:0]      ram_rdata_a;
    logic [MW-1:0]      ram_rdata_b;
    logic [CW-1:0]      a_cnt;
    logic [CW-1:0]      b_cnt;

    // query path follows the threshold; right siblings of left turns add up
    assign q_mid  = r_q_lo + ((r_q_hi - r_q_lo) >> 1);
    assign q_left = (r_thr <= q_mid);
    assign q_lc   = {r_q_node[AW-2:0], 1'b1};
    assign q_rc   = {r_q_node[AW-2:0], 1'b0} + AW'(2);

    // insert path follows the key; every node on it gets one more
    assign u_mid  = r_u_lo + ((r_u_hi - r_u_lo) >> 1);
    assign u_left = (r_key <= u_mid);
    assign u_lc   = {r_u_node[AW-2:0], 1'b1};
    assign u_rc   = {r_u_node[AW-2:0], 1'b0} + AW'(2);

    // entries from an older epoch read as zero
    assign a_cnt = (ram_rdata_a[MW-1:CW] == r_epoch) ? ram_rdata_a[CW-1:0] : '0;
    assign b_cnt = (ram_rdata_b[MW-1:CW] == r_epoch) ? ram_rdata_b[CW-1:0] : '0;

    // clearing pass writes zeros; the walk writes back count plus one in the cycle
    // after its read, one level behind, so the query never sees this insert
    assign ram_we    = (r_state == ST_CLEAR) || r_u_wr;
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_u_waddr;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : {r_epoch, b_cnt + CW'(1)};

    assign sum_total = r_total + TOT_W'(r_acc);

    ctpc_ram #(
        .WIDTH (MW),
        .DEPTH (NODES)
    ) u_nodes (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (q_rc),
        .i_raddr_b (r_u_node),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_epoch     = r_epoch;
        n_items     = r_items;
        n_total     = r_total;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_q_act     = r_q_act;
        n_q_rd      = 1'b0;
        n_u_act     = r_u_act;
        n_u_wr      = 1'b0;
        n_ovf       = r_ovf;
        n_thr       = r_thr;
        n_key       = r_key;
        n_q_node    = r_q_node;
        n_q_lo      = r_q_lo;
        n_q_hi      = r_q_hi;
        n_u_node    = r_u_node;
        n_u_lo      = r_u_lo;
        n_u_hi      = r_u_hi;
        n_u_waddr   = r_u_node;
        n_acc       = r_q_rd ? (r_acc + a_cnt) : r_acc;
        n_out_beat  = r_out_beat;

        // result beat taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_thr    = VW'(i_in_beat.threshold);
                    n_key    = VW'(i_in_beat.new_key);
                    n_acc    = '0;
                    n_q_node = '0;
                    n_q_lo   = '0;
                    n_q_hi   = LAST_KEY;
                    n_u_node = '0;
                    n_u_lo   = '0;
                    n_u_hi   = LAST_KEY;
                    // threshold at or above the top key finds nothing
                    n_q_act  = (VW'(i_in_beat.threshold) < LAST_KEY);
                    // key beyond the leaf range is counted but not stored
                    n_u_act  = (VW'(i_in_beat.new_key) <= LAST_KEY);
                    if (i_in_beat.batch_start) begin
                        n_total = '0;
                        n_items = CW'(1);
                        n_ovf   = 1'b0;
                        if (r_epoch == EPOCH_LAST) begin
                            // tag space used up: real clear, then walk
                            n_epoch    = '0;
                            n_clr_addr = '0;
                            n_pend     = 1'b1;
                            n_state    = ST_CLEAR;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                            n_state = ST_WALK;
                        end
                    end else if (r_items >= FULL_BATCH) begin
                        // batch full: item ignored, flagged
                        n_ovf   = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_ovf   = 1'b0;
                        n_items = r_items + CW'(1);
                        n_state = ST_WALK;
                    end
                end
            end
            ST_CLEAR: begin
                if (r_clr_addr == NODE_LAST) begin
                    n_pend  = 1'b0;
                    n_state = r_pend ? ST_WALK : ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            ST_WALK: begin
                // query: on a left turn fetch the right child's count
                if (r_q_act) begin
                    n_q_rd   = q_left;
                    n_q_node = q_left ? q_lc : q_rc;
                    n_q_lo   = q_left ? r_q_lo : (q_mid + VW'(1));
                    n_q_hi   = q_left ? q_mid : r_q_hi;
                    // at the leaf the key equals the threshold: nothing to add
                    n_q_act  = (n_q_lo < n_q_hi);
                end
                // insert: read this node now, write it back next cycle
                if (r_u_act) begin
                    n_u_wr   = 1'b1;
                    n_u_node = u_left ? u_lc : u_rc;
                    n_u_lo   = u_left ? r_u_lo : (u_mid + VW'(1));
                    n_u_hi   = u_left ? u_mid : r_u_hi;
                    n_u_act  = (r_u_lo < r_u_hi);
                end
                if (!r_q_act && !r_u_act && !r_q_rd && !r_u_wr) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_beat.greater_count = GC_W'(r_acc);
                    n_out_beat.pair_total    = sum_total;
                    n_out_beat.overflow      = r_ovf;
                    n_total                  = sum_total;
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_epoch     <= '0;
            r_items     <= '0;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_q_act     <= 1'b0;
            r_q_rd      <= 1'b0;
            r_u_act     <= 1'b0;
            r_u_wr      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_epoch     <= n_epoch;
            r_items     <= n_items;
            r_total     <= n_total;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_q_act     <= n_q_act;
            r_q_rd      <= n_q_rd;
            r_u_act     <= n_u_act;
            r_u_wr      <= n_u_wr;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_ovf      <= n_ovf;
        r_thr      <= n_thr;
        r_key      <= n_key;
        r_q_node   <= n_q_node;
        r_q_lo     <= n_q_lo;
        r_q_hi     <= n_q_hi;
        r_u_node   <= n_u_node;
        r_u_lo     <= n_u_lo;
        r_u_hi     <= n_u_hi;
        r_u_waddr  <= n_u_waddr;
        r_acc      <= n_acc;
        r_out_beat <= n_out_beat;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
